@@ rtl/core/laat_pkg.sv @@
// Shared constants, types and helpers for the LED array afterglow timers.
// No dependencies; compiled ahead of every other file of the block.
package laat_pkg;

   localparam int LED_LANES        = 64;
   localparam int TIMER_W          = 16;
   localparam int ELAPSED_W        = 32;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 16;
   localparam int GROUP_SIZE       = 4;
   localparam int NUM_GROUPS       = LED_LANES / GROUP_SIZE;
   localparam int NUM_QUADS        = NUM_GROUPS / GROUP_SIZE;
   localparam int DEFAULT_NUM_LEDS = 64;

   localparam logic               RESET_ANODE_WIRING = 1'b1;
   localparam logic [TIMER_W-1:0] RESET_FADE_DELAY   = 16'd10000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ANODE_WIRING = 1'b0,
      CSR_FADE_DELAY   = 1'b1
   } csr_index_type;

   typedef logic [TIMER_W-1:0] timer_type;

   // smaller of two timers where zero means no running timer
   function automatic timer_type min_nonzero(timer_type a, timer_type b);
      timer_type result;
      priority if (a == '0) begin
         result = b;
      end else if (b == '0) begin
         result = a;
      end else if (b < a) begin
         result = b;
      end else begin
         result = a;
      end
      return result;
   endfunction

   function automatic timer_type min_nonzero4(timer_type a, timer_type b,
                                              timer_type c, timer_type d);
      return min_nonzero(min_nonzero(a, b), min_nonzero(c, d));
   endfunction

endpackage

@@ rtl/core/laat_req_if.sv @@
// Request channel of the LED array afterglow timers: pin levels and elapsed time.
// Depends on laat_pkg for field widths.
interface laat_req_if;
   import laat_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  common_level;
   logic [LED_LANES-1:0]  led_levels;
   logic [ELAPSED_W-1:0]  elapsed_us;

   modport source (output valid, output common_level, output led_levels,
                   output elapsed_us, input ready);
   modport sink   (input valid, input common_level, input led_levels,
                   input elapsed_us, output ready);
endinterface

@@ rtl/core/laat_rsp_if.sv @@
// Response channel of the LED array afterglow timers: wakeup time and lit mask.
// Depends on laat_pkg for field widths.
interface laat_rsp_if;
   import laat_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TIMER_W-1:0]    next_wakeup_us;
   logic [LED_LANES-1:0]  lit_mask;

   modport source (output valid, output next_wakeup_us, output lit_mask,
                   input ready);
   modport sink   (input valid, input next_wakeup_us, input lit_mask,
                   output ready);
endinterface

@@ rtl/core/led_array_afterglow_timers_top.sv @@
// Top level of the LED array afterglow timers: per-LED fade timers and min tree.
// Depends on laat_pkg, laat_req_if and laat_rsp_if.
//
// Usage:
//   req_if carries the common pin level, the per-LED pin levels and the
//   microseconds since the previous item; rsp_if returns one item per
//   request with the smallest nonzero fade timer and the lit mask.
//   csr_we/csr_index/csr_wdata write the anode wiring select (index 0) and
//   fade_delay_us (index 1); write them only while the block is idle.
// Timing:
//   One request per cycle sustained while rsp_if.ready holds. A response
//   is registered through the input register, the timer update with a first
//   4:1 min level, a 16:4 min level, and the 4:1 result register.
//   The per-LED timer update is the only loop.
// Reset:
//   Synchronous reset clears all fade timers, empties the pipeline and loads
//   common anode wiring with a 10000 us fade delay.
// Backpressure:
//   Each stage holds only while its successor is full and stalled, so empty
//   stages keep taking requests while a finished response waits on rsp_if.
module led_array_afterglow_timers_top #(
   parameter int NUM_LEDS = laat_pkg::DEFAULT_NUM_LEDS
) (
   input  logic                              clock,
   input  logic                              reset,
   laat_req_if.sink                          req_if,
   laat_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [laat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [laat_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import laat_pkg::*;

   localparam logic [LED_LANES:0]   ONE_EXT   = {{LED_LANES{1'b0}}, 1'b1};
   localparam logic [LED_LANES-1:0] LANE_MASK =
      LED_LANES'((ONE_EXT << NUM_LEDS) - ONE_EXT);

   logic       anode_wiring_ff;
   timer_type  fade_delay_ff;

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic adv0, adv1, adv2, adv3;
   logic move0;

   logic                  s0_common_ff;
   logic [LED_LANES-1:0]  s0_levels_ff;
   logic [ELAPSED_W-1:0]  s0_elapsed_ff;

   timer_type             cand [LED_LANES];
   logic [LED_LANES-1:0]  s1_lit_in;
   timer_type             s1_min_in [NUM_GROUPS];
   timer_type             s1_min_ff [NUM_GROUPS];
   logic [LED_LANES-1:0]  s1_lit_ff;

   timer_type             s2_min_in [NUM_QUADS];
   timer_type             s2_min_ff [NUM_QUADS];
   logic [LED_LANES-1:0]  s2_lit_ff;

   timer_type             s3_min_in;
   timer_type             s3_min_ff;
   logic [LED_LANES-1:0]  s3_lit_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         anode_wiring_ff <= RESET_ANODE_WIRING;
         fade_delay_ff   <= RESET_FADE_DELAY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANODE_WIRING: anode_wiring_ff <= csr_wdata[0];
            CSR_FADE_DELAY:   fade_delay_ff   <= csr_wdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   assign adv3  = !v3_ff || rsp_if.ready;
   assign adv2  = !v2_ff || adv3;
   assign adv1  = !v1_ff || adv2;
   assign adv0  = !v0_ff || adv1;
   assign move0 = v0_ff && adv1;

   assign req_if.ready = adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= req_if.valid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_if.valid && adv0) begin
         s0_common_ff  <= req_if.common_level;
         s0_levels_ff  <= req_if.led_levels;
         s0_elapsed_ff <= req_if.elapsed_us;
      end
   end

   // per-LED fade timers
   for (genvar k = 0; k < LED_LANES; k++) begin : g_lane
      if (k < NUM_LEDS) begin : g_used
         logic       pin;
         logic       powered;
         logic       expired;
         timer_type  decayed;
         timer_type  timer_in;
         timer_type  timer_ff;

         assign pin      = s0_levels_ff[k];
         assign powered  = anode_wiring_ff ? (s0_common_ff & ~pin)
                                           : (pin & ~s0_common_ff);
         assign expired  = {{(ELAPSED_W-TIMER_W){1'b0}}, timer_ff} <= s0_elapsed_ff;
         assign decayed  = expired ? '0 : timer_ff - s0_elapsed_ff[TIMER_W-1:0];
         assign timer_in = powered ? fade_delay_ff : decayed;

         assign s1_lit_in[k] = powered | (decayed != '0);
         assign cand[k]      = powered ? '0 : decayed;

         always_ff @(posedge clock) begin
            if (reset) begin
               timer_ff <= '0;
            end else if (move0) begin
               timer_ff <= timer_in;
            end
         end
      end else begin : g_unused
         assign s1_lit_in[k] = 1'b0;
         assign cand[k]      = '0;
      end
   end

   // min tree: 64 -> 16 -> 4 -> 1
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         s1_min_in[g] = min_nonzero4(cand[GROUP_SIZE*g],     cand[GROUP_SIZE*g + 1],
                                     cand[GROUP_SIZE*g + 2], cand[GROUP_SIZE*g + 3]);
      end
      for (int q = 0; q < NUM_QUADS; q++) begin
         s2_min_in[q] = min_nonzero4(s1_min_ff[GROUP_SIZE*q],
                                     s1_min_ff[GROUP_SIZE*q + 1],
                                     s1_min_ff[GROUP_SIZE*q + 2],
                                     s1_min_ff[GROUP_SIZE*q + 3]);
      end
      s3_min_in = min_nonzero4(s2_min_ff[0], s2_min_ff[1], s2_min_ff[2], s2_min_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_min_ff <= s1_min_in;
         s1_lit_ff <= s1_lit_in;
      end
      if (adv2) begin
         s2_min_ff <= s2_min_in;
         s2_lit_ff <= s1_lit_ff;
      end
      if (adv3) begin
         s3_min_ff <= s3_min_in;
         s3_lit_ff <= s2_lit_ff;
      end
   end

   assign rsp_if.valid          = v3_ff;
   assign rsp_if.next_wakeup_us = s3_min_ff;
   assign rsp_if.lit_mask       = s3_lit_ff;

`ifndef NO_ASSERTIONS
   a_wakeup_implies_lit : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.next_wakeup_us != '0) |-> (rsp_if.lit_mask != '0))
      else $error("running timer reported with empty lit mask");

   a_unused_lanes_dark : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.lit_mask & ~LANE_MASK) == '0))
      else $error("lit bit set beyond the configured LED count");

   a_reset_empties : assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid && !v0_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
